@@ design/int4_weight_dequant_nz_defines.svh @@
// Assertion macros used by the dequantizer top level.
`ifndef INT4_WEIGHT_DEQUANT_NZ_DEFINES_SVH
`define INT4_WEIGHT_DEQUANT_NZ_DEFINES_SVH
`ifndef ASSERT_OFF
`define DQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dequantizer assertion failed");
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dequantizer assertion failed");
`else
`define DQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/i4dq_pkg.sv @@
// Shared constants, types and the NZ address function of the dequantizer.
`default_nettype none
package i4dq_pkg;
    localparam int ROWS         = 128;
    localparam int COLUMNS      = 64;
    localparam int FRACTAL_SIDE = 16;
    localparam int KBLOCKS      = ROWS / FRACTAL_SIDE;
    localparam int LANES        = 8;
    localparam int LANE_W       = 3;
    localparam int COL_W        = 6;
    localparam int GROUP_W      = 3;
    localparam int ROW_W        = 7;
    localparam int ADDR_W       = 13;
    localparam int HALF_W       = 16;
    localparam int WORD_W       = 32;
    localparam int ENTRY_W      = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);
    localparam logic [HALF_W-1:0] HALF_QNAN = 16'h7E00;
    localparam logic [HALF_W-1:0] HALF_INF  = 16'h7C00;

    typedef struct packed {
        logic [ADDR_W-1:0] nz;
        logic              last;
    } lane_meta_t;

    typedef struct packed {
        logic o_inf;
        logic o_nan;
        logic o_sign;
        logic s_zero;
        logic s_inf;
        logic s_nan;
        logic s_sign;
        logic sum_zero;
        logic sum_sign;
    } cls_t;

    function automatic logic [ADDR_W-1:0] nz_pos(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        int r;
        int c;
        int p;
        r = int'(row);
        c = int'(col) % COLUMNS;
        p = (((c / FRACTAL_SIDE) * KBLOCKS + r / FRACTAL_SIDE) * FRACTAL_SIDE
             + r % FRACTAL_SIDE) * FRACTAL_SIDE + c % FRACTAL_SIDE;
        return ADDR_W'(p);
    endfunction
endpackage
`default_nettype wire

@@ design/i4dq_ram.sv @@
// Generic single-write, single-read RAM with a registered, read-first output.
`default_nettype none
module i4dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ design/i4dq_datapath.sv @@
// Floating-point pipeline: offset add, fp32 rounding, scale multiply, fp16 rounding.
`default_nettype none
module i4dq_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        v1,
    input  logic [3:0]                  nib1,
    input  i4dq_pkg::lane_meta_t        meta1,
    input  logic [i4dq_pkg::ENTRY_W-1:0] entry1,
    input  logic                        out_ready,
    output logic                        adv,
    output logic                        out_valid,
    output logic [i4dq_pkg::ADDR_W-1:0] nz_address,
    output logic [i4dq_pkg::HALF_W-1:0] weight_value,
    output logic                        last_lane
);
    import i4dq_pkg::*;

    localparam int FRAC  = 24;
    localparam int FIX_W = 41;
    localparam int SUM_W = 42;

    logic [HALF_W-1:0] off_h;
    logic [HALF_W-1:0] scl_h;
    logic [FIX_W-1:0]  o_mag;
    logic [SUM_W-1:0]  q_ext;
    logic [SUM_W-1:0]  sum_c;
    logic [3:0]        s_k;
    logic [10:0]       ms_c;
    logic signed [6:0] es_c;
    cls_t              cls_c;
    cls_t              cls2_c;

    logic              v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    lane_meta_t        meta2_reg, meta3_reg, meta4_reg, meta5_reg, meta6_reg, meta_o_reg;
    cls_t              cls2_reg, cls3_reg, cls4_reg, cls5_reg, cls6_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic [10:0]       ms2_reg, ms3_reg, ms4_reg;
    logic signed [6:0] es2_reg, es3_reg, es4_reg;
    logic [FIX_W-1:0]  mag3_reg;
    logic [5:0]        p3_reg;
    logic [23:0]       m4_reg;
    logic [5:0]        ps4_reg;
    logic [34:0]       prod5_reg;
    logic signed [8:0] t5_reg;
    logic [23:0]       m6_reg;
    logic signed [8:0] e6_reg;
    logic [HALF_W-1:0] w_o_reg;

    logic [FIX_W-1:0]  mag_c;
    logic [5:0]        p_c;
    logic [FIX_W-1:0]  norm_c;
    logic              up3_c;
    logic [24:0]       m25_c;
    logic [23:0]       m24_c;
    logic [5:0]        ps_c;
    logic [34:0]       prod_c;
    logic signed [8:0] t0_c;
    logic [34:0]       pn_c;
    logic signed [8:0] t_c;
    logic              up5_c;
    logic [24:0]       mp25_c;
    logic [23:0]       mp_c;
    logic signed [8:0] e_c;
    logic [4:0]        sh_c;
    logic [HALF_W-1:0] base_c;
    logic [47:0]       x_c;
    logic              up6_c;
    logic [HALF_W-1:0] h_c;
    logic [HALF_W-1:0] w_c;
    logic              nan_c;
    logic              inf_c;
    logic              zero_c;
    logic              sgn_c;

    assign adv = !vo_reg || out_ready;

    // Stage one: offset to fixed point (units of 2^-24), add the weight, decode the scale.
    assign off_h = entry1[HALF_W-1:0];
    assign scl_h = entry1[ENTRY_W-1:HALF_W];
    assign o_mag = (off_h[14:10] == 5'd0) ? FIX_W'(off_h[9:0])
                 : (FIX_W'({1'b1, off_h[9:0]}) << (off_h[14:10] - 5'd1));
    assign q_ext = {{(SUM_W - 4 - FRAC){nib1[3]}}, nib1, {FRAC{1'b0}}};
    assign sum_c = off_h[15] ? (q_ext - {1'b0, o_mag}) : (q_ext + {1'b0, o_mag});

    always_comb
    begin
        s_k = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (scl_h[i])
            begin
                s_k = 4'(i);
            end
        end
        if (scl_h[14:10] == 5'd0)
        begin
            ms_c = 11'({1'b0, scl_h[9:0]} << (4'd10 - s_k));
            es_c = 7'sd34 * -7'sd1 + $signed({3'b000, s_k});
        end
        else
        begin
            ms_c = {1'b1, scl_h[9:0]};
            es_c = $signed({2'b00, scl_h[14:10]}) - 7'sd25;
        end
        cls_c.o_inf    = (off_h[14:10] == 5'h1F) && (off_h[9:0] == 10'd0);
        cls_c.o_nan    = (off_h[14:10] == 5'h1F) && (off_h[9:0] != 10'd0);
        cls_c.o_sign   = off_h[15];
        cls_c.s_zero   = (scl_h[14:0] == 15'd0);
        cls_c.s_inf    = (scl_h[14:10] == 5'h1F) && (scl_h[9:0] == 10'd0);
        cls_c.s_nan    = (scl_h[14:10] == 5'h1F) && (scl_h[9:0] != 10'd0);
        cls_c.s_sign   = scl_h[15];
        cls_c.sum_zero = 1'b0;
        cls_c.sum_sign = 1'b0;
    end

    // Stage two: magnitude and leading-one position of the sum.
    always_comb
    begin
        mag_c = sum2_reg[SUM_W-1] ? FIX_W'(-sum2_reg) : sum2_reg[FIX_W-1:0];
        p_c   = 6'd0;
        for (int i = 0; i < FIX_W; i++)
        begin
            if (mag_c[i])
            begin
                p_c = 6'(i);
            end
        end
        cls2_c          = cls2_reg;
        cls2_c.sum_zero = (mag_c == '0);
        cls2_c.sum_sign = sum2_reg[SUM_W-1];
    end

    // Stage three: normalise and round the sum to a 24-bit fp32 significand.
    always_comb
    begin
        norm_c = mag3_reg << (6'(FIX_W - 1) - p3_reg);
        up3_c  = norm_c[16] && ((|norm_c[15:0]) || norm_c[17]);
        m25_c  = {1'b0, norm_c[40:17]} + 25'(up3_c);
        if (m25_c[24])
        begin
            m24_c = 24'h800000;
            ps_c  = p3_reg + 6'd1;
        end
        else
        begin
            m24_c = m25_c[23:0];
            ps_c  = p3_reg;
        end
    end

    // Stage four: significand product.
    assign prod_c = 35'(m4_reg) * 35'(ms4_reg);
    assign t0_c   = $signed({3'b000, ps4_reg}) - 9'sd47 + 9'(es4_reg);

    // Stage five: normalise and round the product to fp32.
    always_comb
    begin
        if (prod5_reg[34])
        begin
            pn_c = prod5_reg;
            t_c  = t5_reg;
        end
        else
        begin
            pn_c = {prod5_reg[33:0], 1'b0};
            t_c  = t5_reg - 9'sd1;
        end
        up5_c  = pn_c[10] && ((|pn_c[9:0]) || pn_c[11]);
        mp25_c = {1'b0, pn_c[34:11]} + 25'(up5_c);
        if (mp25_c[24])
        begin
            mp_c = 24'h800000;
            e_c  = t_c + 9'sd35;
        end
        else
        begin
            mp_c = mp25_c[23:0];
            e_c  = t_c + 9'sd34;
        end
    end

    // Stage six: fp32 to fp16 with nearest-even rounding and special values.
    always_comb
    begin
        if (e6_reg >= -9'sd14)
        begin
            sh_c   = 5'd13;
            base_c = HALF_W'(e6_reg + 9'sd14) << 10;
        end
        else
        begin
            sh_c   = 5'(-9'sd1 - e6_reg);
            base_c = '0;
        end
        x_c   = {m6_reg, 24'd0} >> sh_c;
        up6_c = x_c[23] && ((|x_c[22:0]) || x_c[24]);
        h_c   = base_c + HALF_W'(x_c[47:24]) + HALF_W'(up6_c);
        if (e6_reg > 9'sd15)
        begin
            h_c = HALF_INF;
        end
        else if (e6_reg < -9'sd25)
        begin
            h_c = '0;
        end
        nan_c  = cls6_reg.o_nan || cls6_reg.s_nan || (cls6_reg.o_inf && cls6_reg.s_zero)
              || (!cls6_reg.o_inf && cls6_reg.sum_zero && cls6_reg.s_inf);
        inf_c  = cls6_reg.o_inf || cls6_reg.s_inf;
        zero_c = cls6_reg.sum_zero || cls6_reg.s_zero;
        sgn_c  = (cls6_reg.o_inf ? cls6_reg.o_sign : cls6_reg.sum_sign) ^ cls6_reg.s_sign;
        if (nan_c)
        begin
            w_c = HALF_QNAN;
        end
        else if (inf_c)
        begin
            w_c = {sgn_c, HALF_INF[14:0]};
        end
        else if (zero_c)
        begin
            w_c = {sgn_c, 15'd0};
        end
        else
        begin
            w_c = {sgn_c, h_c[14:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            vo_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta2_reg  <= meta1;
            sum2_reg   <= sum_c;
            cls2_reg   <= cls_c;
            ms2_reg    <= ms_c;
            es2_reg    <= es_c;

            meta3_reg  <= meta2_reg;
            mag3_reg   <= mag_c;
            p3_reg     <= p_c;
            cls3_reg   <= cls2_c;
            ms3_reg    <= ms2_reg;
            es3_reg    <= es2_reg;

            meta4_reg  <= meta3_reg;
            m4_reg     <= m24_c;
            ps4_reg    <= ps_c;
            cls4_reg   <= cls3_reg;
            ms4_reg    <= ms3_reg;
            es4_reg    <= es3_reg;

            meta5_reg  <= meta4_reg;
            prod5_reg  <= prod_c;
            t5_reg     <= t0_c;
            cls5_reg   <= cls4_reg;

            meta6_reg  <= meta5_reg;
            m6_reg     <= mp_c;
            e6_reg     <= e_c;
            cls6_reg   <= cls5_reg;

            meta_o_reg <= meta6_reg;
            w_o_reg    <= w_c;
        end
    end

    assign out_valid    = vo_reg;
    assign nz_address   = meta_o_reg.nz;
    assign weight_value = w_o_reg;
    assign last_lane    = meta_o_reg.last;
endmodule
`default_nettype wire

@@ design/int4_weight_dequant_nz.sv @@
// Top level of the packed int4 weight dequantizer with NZ addressing.
//
// One request channel (in_valid/in_ready) carries two kinds of request. A load
// request writes one column's fp16 scale and offset into the table memory and
// produces no result. A decode request carries eight signed nibbles for one row
// and one group of eight columns and produces eight results, lane 0 first, on
// the result channel (out_valid/out_ready); the eighth has last_lane set.
// Each lane is read from the table and registered into the lane registers, then
// passes the datapath stages and its output register before its result is valid.
// A decode occupies the table read port one lane per cycle while nothing stalls,
// and the next request is taken in the cycle of its last lane, so decodes follow
// each other with one result per cycle while the receiver does not stall.
// A load is written into the table when accepted. When the receiver stalls, the
// whole pipeline and the lane sequencer hold; requests are taken again as soon as
// results drain. Reset empties the pipeline and the sequencer; the table contents
// are undefined until loaded, and a column must be loaded before it is decoded.
`default_nettype none
`include "int4_weight_dequant_nz_defines.svh"
module int4_weight_dequant_nz (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [i4dq_pkg::COL_W-1:0]   column_index,
    input  logic [i4dq_pkg::HALF_W-1:0]  scale_value,
    input  logic [i4dq_pkg::HALF_W-1:0]  offset_value,
    input  logic [i4dq_pkg::WORD_W-1:0]  packed_word,
    input  logic [i4dq_pkg::ROW_W-1:0]   row_index,
    input  logic [i4dq_pkg::GROUP_W-1:0] column_group,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [i4dq_pkg::ADDR_W-1:0]  nz_address,
    output logic [i4dq_pkg::HALF_W-1:0]  weight_value,
    output logic                         last_lane
);
    import i4dq_pkg::*;

    logic                busy_reg, busy_next;
    logic [LANE_W-1:0]   lane_reg, lane_next;
    logic [WORD_W-1:0]   word_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [GROUP_W-1:0]  group_reg;
    logic                v1_reg;
    logic [3:0]          nib1_reg;
    lane_meta_t          meta1_reg;

    logic                adv;
    logic                accept;
    logic                acc_dec;
    logic                issue;
    logic [COL_W-1:0]    rd_col;
    logic [ENTRY_W-1:0]  entry;

    assign in_ready = adv && (!busy_reg || (lane_reg == LAST_LANE));
    assign accept   = in_valid && in_ready;
    assign acc_dec  = accept && (opcode == OP_DECODE);
    assign issue    = adv && busy_reg;
    assign rd_col   = {group_reg, lane_reg};

    always_comb
    begin
        busy_next = busy_reg;
        lane_next = lane_reg;
        if (acc_dec)
        begin
            busy_next = 1'b1;
            lane_next = '0;
        end
        else if (issue)
        begin
            busy_next = (lane_reg != LAST_LANE);
            lane_next = lane_reg + LANE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lane_reg <= '0;
            v1_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            lane_reg <= lane_next;
            if (adv)
            begin
                v1_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_dec)
        begin
            word_reg  <= packed_word;
            row_reg   <= row_index;
            group_reg <= column_group;
        end
        if (adv)
        begin
            nib1_reg  <= word_reg[lane_reg * 4 +: 4];
            meta1_reg <= '{nz: nz_pos(row_reg, rd_col), last: (lane_reg == LAST_LANE)};
        end
    end

    i4dq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (COLUMNS)
    ) u_table (
        .clk   (clk),
        .we    (accept && (opcode == OP_LOAD)),
        .waddr (column_index),
        .wdata ({scale_value, offset_value}),
        .re    (issue),
        .raddr (rd_col),
        .rdata (entry)
    );

    i4dq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .v1           (v1_reg),
        .nib1         (nib1_reg),
        .meta1        (meta1_reg),
        .entry1       (entry),
        .out_ready    (out_ready),
        .adv          (adv),
        .out_valid    (out_valid),
        .nz_address   (nz_address),
        .weight_value (weight_value),
        .last_lane    (last_lane)
    );

    `DQ_ASSERT_IMPL(a_ready_only_on_last, clk, rst_n, busy_reg && in_ready, lane_reg == LAST_LANE)
    `DQ_ASSERT_NEXT(a_decode_starts, clk, rst_n, acc_dec, busy_reg && (lane_reg == '0))
    `DQ_ASSERT_NEXT(a_stall_holds_lane, clk, rst_n, out_valid && !out_ready && busy_reg, $stable(lane_reg))
endmodule
`default_nettype wire
